### rtl/core/dtas_pkg.sv
// shared types, field widths and calendar helpers for the date-time add/subtract block
// no dependencies; used by dtas_alu, dtas_leap and date_time_add_subtract
`default_nettype none

package dtas_pkg;

  localparam int OP_W   = 4;
  localparam int AMT_W  = 8;
  localparam int YEAR_W = 14;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;
  localparam int CNT_W  = 4;
  localparam int ALU_W  = 16;

  localparam int IN_AMT_LSB  = 0;
  localparam int IN_YEAR_LSB = IN_AMT_LSB + AMT_W;
  localparam int IN_MON_LSB  = IN_YEAR_LSB + YEAR_W;
  localparam int IN_DAY_LSB  = IN_MON_LSB + MON_W;
  localparam int IN_HOUR_LSB = IN_DAY_LSB + DAY_W;
  localparam int IN_MIN_LSB  = IN_HOUR_LSB + HOUR_W;
  localparam int IN_SEC_LSB  = IN_MIN_LSB + MIN_W;
  localparam int IN_BITS     = IN_SEC_LSB + SEC_W;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;

  localparam int OUT_YEAR_LSB = 0;
  localparam int OUT_MON_LSB  = OUT_YEAR_LSB + YEAR_W;
  localparam int OUT_DAY_LSB  = OUT_MON_LSB + MON_W;
  localparam int OUT_HOUR_LSB = OUT_DAY_LSB + DAY_W;
  localparam int OUT_MIN_LSB  = OUT_HOUR_LSB + HOUR_W;
  localparam int OUT_SEC_LSB  = OUT_MIN_LSB + MIN_W;
  localparam int OUT_BITS     = OUT_SEC_LSB + SEC_W;
  localparam int OUT_DATA_W   = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_SUB_BASE = 4'd6;
  localparam logic [OP_W-1:0] OP_LIMIT    = 4'd12;

  localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
  localparam logic [MON_W-1:0]  MON_MAX  = 4'd12;
  localparam logic [HOUR_W-1:0] HOUR_MAX = 5'd23;
  localparam logic [MIN_W-1:0]  MIN_MAX  = 6'd59;

  localparam int SECS_PER_MIN  = 60;
  localparam int HOURS_PER_DAY = 24;
  localparam int MONTHS        = 12;

  // year % 25 == 0 test through the inverse of 25 modulo 2^14
  localparam logic [YEAR_W-1:0] DIV25_INV = 14'd7209;
  localparam logic [YEAR_W-1:0] DIV25_LIM = 14'd655;

  // amount / 12 as (amount * 171) >> 11, exact for 0..255
  localparam logic [AMT_W-1:0] RECIP12    = 8'd171;
  localparam int               RECIP12_SH = 11;
  localparam int               QUOT_W     = 5;

  typedef enum logic [2:0] {
    UNIT_SEC   = 3'd0,
    UNIT_MIN   = 3'd1,
    UNIT_HOUR  = 3'd2,
    UNIT_DAY   = 3'd3,
    UNIT_MONTH = 3'd4,
    UNIT_YEAR  = 3'd5
  } unit_t;

  typedef struct packed {
    logic signed [ALU_W-1:0] a;
    logic signed [ALU_W-1:0] b;
    logic                    sub;
  } alu_req_t;

  typedef struct packed {
    logic signed [ALU_W-1:0] sum;
    logic                    neg;
    logic                    zero;
  } alu_rsp_t;

  function automatic logic leap_of(input logic [YEAR_W-1:0] year);
    logic [YEAR_W-1:0] prod;
    logic              div25;
    prod  = year * DIV25_INV;
    div25 = (prod <= DIV25_LIM);
    return ((year[1:0] == 2'd0) && !div25) || ((year[3:0] == 4'd0) && div25);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] month,
                                                  input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      4'd2: begin
        len = leap ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        len = 5'd30;
      end
      default: begin
        len = 5'd31;
      end
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### rtl/core/dtas_alu.sv
// shared add/subtract unit used by the carry, borrow and month steps
// depends on dtas_pkg for the request and response structs
`default_nettype none

module dtas_alu (
  input  dtas_pkg::alu_req_t req,
  output dtas_pkg::alu_rsp_t rsp
);

  logic signed [dtas_pkg::ALU_W-1:0] sum;

  assign sum      = req.sub ? (req.a - req.b) : (req.a + req.b);
  assign rsp.sum  = sum;
  assign rsp.neg  = sum[dtas_pkg::ALU_W-1];
  assign rsp.zero = (sum == '0);

endmodule

`default_nettype wire

### rtl/core/dtas_leap.sv
// registered leap-year flag for the working year, valid in the cycle after the year settles
// depends on dtas_pkg::leap_of
`default_nettype none

module dtas_leap (
  input  wire logic                         clk,
  input  wire logic [dtas_pkg::YEAR_W-1:0]  year,
  output logic                              leap
);

  always_ff @(posedge clk) begin
    leap <= dtas_pkg::leap_of(year);
  end

endmodule

`default_nettype wire

### rtl/core/date_time_add_subtract.sv
// top level: request sequencer, working date-time registers and output register
// depends on dtas_pkg, dtas_alu and dtas_leap
//
// Gregorian date-time add/subtract. A request on the s_axis channel carries an
// opcode in tuser (add or subtract seconds, minutes, hours, days, months, years)
// and the amount plus base date-time in tdata. The m_axis channel returns the
// new date-time in tdata and the year overflow flag in tuser; on overflow the
// returned fields equal the (saturated) base.
// One request is worked at a time: s_axis_tready is high only while idle.
// Carries walk through seconds, minutes and hours one modulus step per cycle,
// days walk one month at a time, and field and day sums go through the single
// shared adder; a year change passes through a wait state for the registered
// leap-year flag. Zero amounts skip the arithmetic steps.
// The result waits in the output register while m_axis_tready is low; the
// next request is taken meanwhile and its result is held back until the
// register empties.
// Synchronous reset returns the sequencer to idle and empties the output.
`default_nettype none

module date_time_add_subtract (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // amount, base_year, base_month, base_day, base_hour, base_minute, base_second
  input  wire logic [dtas_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // opcode
  input  wire logic [dtas_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // result_year, result_month, result_day, result_hour, result_minute, result_second
  output logic [dtas_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // year_overflow
  output logic [0:0]                              m_axis_tuser
);

  localparam int ALU_W  = dtas_pkg::ALU_W;
  localparam int T_W    = 10;
  localparam int YR_W   = dtas_pkg::YEAR_W + 1;

  typedef enum logic [17:0] {
    ST_IDLE   = 18'h00001,
    ST_SAT    = 18'h00002,
    ST_LWAIT  = 18'h00004,
    ST_DSAT   = 18'h00008,
    ST_FSTART = 18'h00010,
    ST_FNORM  = 18'h00020,
    ST_DSTART = 18'h00040,
    ST_DADD   = 18'h00080,
    ST_DSUB   = 18'h00100,
    ST_DADJ   = 18'h00200,
    ST_MQ     = 18'h00400,
    ST_MR     = 18'h00800,
    ST_MY     = 18'h01000,
    ST_MFIX   = 18'h02000,
    ST_MSET   = 18'h04000,
    ST_YR     = 18'h08000,
    ST_CLAMP  = 18'h10000,
    ST_FIN    = 18'h20000
  } state_t;

  state_t state;
  state_t ret_state;

  dtas_pkg::unit_t unit;
  dtas_pkg::unit_t fld;
  logic            sub;
  logic            op_ok;
  logic            keep_last;

  logic [dtas_pkg::AMT_W-1:0]  c;
  logic [dtas_pkg::CNT_W-1:0]  cnt;
  logic [dtas_pkg::QUOT_W-1:0] q;

  logic signed [YR_W-1:0]       yr;
  logic [dtas_pkg::MON_W-1:0]   mon;
  logic signed [T_W-1:0]        day;
  logic [dtas_pkg::HOUR_W-1:0]  hr;
  logic [dtas_pkg::MIN_W-1:0]   mn;
  logic [dtas_pkg::SEC_W-1:0]   sc;
  logic signed [T_W-1:0]        t;

  logic [dtas_pkg::YEAR_W-1:0]  b_yr;
  logic [dtas_pkg::MON_W-1:0]   b_mon;
  logic [dtas_pkg::DAY_W-1:0]   b_day;
  logic [dtas_pkg::HOUR_W-1:0]  b_hr;
  logic [dtas_pkg::MIN_W-1:0]   b_mn;
  logic [dtas_pkg::SEC_W-1:0]   b_sc;

  logic                         leap;
  logic [dtas_pkg::DAY_W-1:0]   len;
  logic                         yr_ok;
  logic [dtas_pkg::MIN_W-1:0]   fval;
  logic [ALU_W-1:0]             modulus;
  logic [dtas_pkg::AMT_W-1:0]   rem;
  logic [2*dtas_pkg::AMT_W-1:0] qprod;
  logic                         out_free;

  logic [dtas_pkg::YEAR_W-1:0]  sat_yr;
  logic [dtas_pkg::MON_W-1:0]   sat_mon;
  logic [dtas_pkg::HOUR_W-1:0]  sat_hr;
  logic [dtas_pkg::MIN_W-1:0]   sat_mn;
  logic [dtas_pkg::SEC_W-1:0]   sat_sc;
  logic [dtas_pkg::DAY_W-1:0]   sat_day;

  dtas_pkg::alu_req_t alu_req;
  dtas_pkg::alu_rsp_t alu_rsp;

  dtas_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  dtas_leap u_leap (
    .clk  (clk),
    .year (yr[dtas_pkg::YEAR_W-1:0]),
    .leap (leap)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign len   = dtas_pkg::month_len(mon, leap);
  assign yr_ok = !yr[YR_W-1] && (yr[dtas_pkg::YEAR_W-1:0] >= dtas_pkg::YEAR_MIN)
                 && (yr[dtas_pkg::YEAR_W-1:0] <= dtas_pkg::YEAR_MAX);

  assign qprod = (2*dtas_pkg::AMT_W)'(c) * (2*dtas_pkg::AMT_W)'(dtas_pkg::RECIP12);
  assign rem   = c - dtas_pkg::AMT_W'(q) * dtas_pkg::AMT_W'(dtas_pkg::MONTHS);

  always_comb begin
    priority if (fld == dtas_pkg::UNIT_SEC) begin
      fval    = sc;
      modulus = ALU_W'(dtas_pkg::SECS_PER_MIN);
    end else if (fld == dtas_pkg::UNIT_MIN) begin
      fval    = mn;
      modulus = ALU_W'(dtas_pkg::SECS_PER_MIN);
    end else begin
      fval    = dtas_pkg::MIN_W'(hr);
      modulus = ALU_W'(dtas_pkg::HOURS_PER_DAY);
    end
  end

  // input saturation into legal ranges
  always_comb begin
    logic [dtas_pkg::DAY_W-1:0] raw_day;
    raw_day = day[dtas_pkg::DAY_W-1:0];
    if (yr[dtas_pkg::YEAR_W-1:0] < dtas_pkg::YEAR_MIN) begin
      sat_yr = dtas_pkg::YEAR_MIN;
    end else if (yr[dtas_pkg::YEAR_W-1:0] > dtas_pkg::YEAR_MAX) begin
      sat_yr = dtas_pkg::YEAR_MAX;
    end else begin
      sat_yr = yr[dtas_pkg::YEAR_W-1:0];
    end
    if (mon == '0) begin
      sat_mon = 4'd1;
    end else if (mon > dtas_pkg::MON_MAX) begin
      sat_mon = dtas_pkg::MON_MAX;
    end else begin
      sat_mon = mon;
    end
    sat_hr = (hr > dtas_pkg::HOUR_MAX) ? dtas_pkg::HOUR_MAX : hr;
    sat_mn = (mn > dtas_pkg::MIN_MAX) ? dtas_pkg::MIN_MAX : mn;
    sat_sc = (sc > dtas_pkg::MIN_MAX) ? dtas_pkg::MIN_MAX : sc;
    if (raw_day == '0) begin
      sat_day = 5'd1;
    end else if (raw_day > len) begin
      sat_day = len;
    end else begin
      sat_day = raw_day;
    end
  end

  // operand select for the shared adder
  always_comb begin
    alu_req.a   = '0;
    alu_req.b   = '0;
    alu_req.sub = 1'b0;
    case (state)
      ST_FSTART: begin
        alu_req.a   = ALU_W'(fval);
        alu_req.b   = ALU_W'(c);
        alu_req.sub = sub;
      end
      ST_FNORM: begin
        alu_req.a   = ALU_W'(t);
        alu_req.b   = modulus;
        alu_req.sub = !sub;
      end
      ST_DSTART: begin
        alu_req.a   = ALU_W'(day);
        alu_req.b   = ALU_W'(c);
        alu_req.sub = sub;
      end
      ST_DADD: begin
        alu_req.a   = ALU_W'(day);
        alu_req.b   = ALU_W'(len);
        alu_req.sub = 1'b1;
      end
      ST_DADJ: begin
        alu_req.a   = ALU_W'(day);
        alu_req.b   = ALU_W'(len);
        alu_req.sub = 1'b0;
      end
      ST_MR: begin
        alu_req.a   = ALU_W'(mon - 4'd1);
        alu_req.b   = ALU_W'(rem);
        alu_req.sub = sub;
      end
      ST_MY: begin
        alu_req.a   = ALU_W'(yr);
        alu_req.b   = ALU_W'(q);
        alu_req.sub = sub;
      end
      ST_MFIX: begin
        alu_req.a   = ALU_W'(t);
        alu_req.b   = ALU_W'(dtas_pkg::MONTHS);
        alu_req.sub = !t[T_W-1];
      end
      ST_YR: begin
        alu_req.a   = ALU_W'(yr);
        alu_req.b   = ALU_W'(c);
        alu_req.sub = sub;
      end
      default: begin
        alu_req.sub = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      ret_state     <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            yr  <= YR_W'(s_axis_tdata[dtas_pkg::IN_YEAR_LSB +: dtas_pkg::YEAR_W]);
            mon <= s_axis_tdata[dtas_pkg::IN_MON_LSB +: dtas_pkg::MON_W];
            day <= T_W'(s_axis_tdata[dtas_pkg::IN_DAY_LSB +: dtas_pkg::DAY_W]);
            hr  <= s_axis_tdata[dtas_pkg::IN_HOUR_LSB +: dtas_pkg::HOUR_W];
            mn  <= s_axis_tdata[dtas_pkg::IN_MIN_LSB +: dtas_pkg::MIN_W];
            sc  <= s_axis_tdata[dtas_pkg::IN_SEC_LSB +: dtas_pkg::SEC_W];
            c   <= s_axis_tdata[dtas_pkg::IN_AMT_LSB +: dtas_pkg::AMT_W];
            priority if (s_axis_tuser < dtas_pkg::OP_SUB_BASE) begin
              unit  <= dtas_pkg::unit_t'(s_axis_tuser[2:0]);
              sub   <= 1'b0;
              op_ok <= 1'b1;
            end else if (s_axis_tuser < dtas_pkg::OP_LIMIT) begin
              unit  <= dtas_pkg::unit_t'(3'(s_axis_tuser - dtas_pkg::OP_SUB_BASE));
              sub   <= 1'b1;
              op_ok <= 1'b1;
            end else begin
              unit  <= dtas_pkg::UNIT_SEC;
              sub   <= 1'b0;
              op_ok <= 1'b0;
            end
            state <= ST_SAT;
          end
        end
        ST_SAT: begin
          yr        <= YR_W'(sat_yr);
          mon       <= sat_mon;
          hr        <= sat_hr;
          mn        <= sat_mn;
          sc        <= sat_sc;
          b_yr      <= sat_yr;
          b_mon     <= sat_mon;
          b_hr      <= sat_hr;
          b_mn      <= sat_mn;
          b_sc      <= sat_sc;
          ret_state <= ST_DSAT;
          state     <= ST_LWAIT;
        end
        ST_LWAIT: begin
          state <= ret_state;
        end
        ST_DSAT: begin
          day   <= T_W'(sat_day);
          b_day <= sat_day;
          if (!op_ok || (c == '0)) begin
            state <= ST_FIN;
          end else begin
            case (unit)
              dtas_pkg::UNIT_SEC, dtas_pkg::UNIT_MIN, dtas_pkg::UNIT_HOUR: begin
                fld   <= unit;
                state <= ST_FSTART;
              end
              dtas_pkg::UNIT_DAY: begin
                state <= ST_DSTART;
              end
              dtas_pkg::UNIT_MONTH: begin
                state <= ST_MQ;
              end
              dtas_pkg::UNIT_YEAR: begin
                state <= ST_YR;
              end
              default: begin
                state <= ST_FIN;
              end
            endcase
          end
        end
        ST_FSTART: begin
          t     <= alu_rsp.sum[T_W-1:0];
          cnt   <= '0;
          state <= ST_FNORM;
        end
        ST_FNORM: begin
          if (sub ? t[T_W-1] : !alu_rsp.neg) begin
            t   <= alu_rsp.sum[T_W-1:0];
            cnt <= cnt + 1'b1;
          end else begin
            case (fld)
              dtas_pkg::UNIT_SEC: begin
                sc <= t[dtas_pkg::SEC_W-1:0];
              end
              dtas_pkg::UNIT_MIN: begin
                mn <= t[dtas_pkg::MIN_W-1:0];
              end
              default: begin
                hr <= t[dtas_pkg::HOUR_W-1:0];
              end
            endcase
            c <= dtas_pkg::AMT_W'(cnt);
            priority if (cnt == '0) begin
              state <= ST_FIN;
            end else if (fld == dtas_pkg::UNIT_HOUR) begin
              state <= ST_DSTART;
            end else begin
              fld   <= dtas_pkg::unit_t'(fld + 3'd1);
              state <= ST_FSTART;
            end
          end
        end
        ST_DSTART: begin
          day   <= alu_rsp.sum[T_W-1:0];
          state <= sub ? ST_DSUB : ST_DADD;
        end
        // day past month end: drop one month length and move on
        ST_DADD: begin
          if (!alu_rsp.neg && !alu_rsp.zero) begin
            day <= alu_rsp.sum[T_W-1:0];
            if (mon == dtas_pkg::MON_MAX) begin
              mon       <= 4'd1;
              yr        <= yr + 1'b1;
              ret_state <= ST_DADD;
              state     <= ST_LWAIT;
            end else begin
              mon <= mon + 1'b1;
            end
          end else begin
            state <= ST_FIN;
          end
        end
        // day below one: step back a month, then add its length
        ST_DSUB: begin
          if (day[T_W-1] || (day == '0)) begin
            if (mon == 4'd1) begin
              mon       <= dtas_pkg::MON_MAX;
              yr        <= yr - 1'b1;
              ret_state <= ST_DADJ;
              state     <= ST_LWAIT;
            end else begin
              mon   <= mon - 1'b1;
              state <= ST_DADJ;
            end
          end else begin
            state <= ST_FIN;
          end
        end
        ST_DADJ: begin
          day   <= alu_rsp.sum[T_W-1:0];
          state <= ST_DSUB;
        end
        ST_MQ: begin
          q         <= qprod[dtas_pkg::RECIP12_SH +: dtas_pkg::QUOT_W];
          keep_last <= sub && (day[dtas_pkg::DAY_W-1:0] == len);
          state     <= ST_MR;
        end
        ST_MR: begin
          t     <= alu_rsp.sum[T_W-1:0];
          state <= ST_MY;
        end
        ST_MY: begin
          yr    <= alu_rsp.sum[YR_W-1:0];
          state <= ST_MFIX;
        end
        ST_MFIX: begin
          if (t[T_W-1]) begin
            t  <= alu_rsp.sum[T_W-1:0];
            yr <= yr - 1'b1;
          end else if (t >= T_W'(dtas_pkg::MONTHS)) begin
            t  <= alu_rsp.sum[T_W-1:0];
            yr <= yr + 1'b1;
          end
          state <= ST_MSET;
        end
        ST_MSET: begin
          mon       <= t[dtas_pkg::MON_W-1:0] + 4'd1;
          ret_state <= ST_CLAMP;
          state     <= ST_LWAIT;
        end
        ST_YR: begin
          yr        <= alu_rsp.sum[YR_W-1:0];
          keep_last <= 1'b0;
          ret_state <= ST_CLAMP;
          state     <= ST_LWAIT;
        end
        ST_CLAMP: begin
          if (yr_ok && ((day[dtas_pkg::DAY_W-1:0] > len) || keep_last)) begin
            day <= T_W'(len);
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result register, base returned on year overflow
  always_ff @(posedge clk) begin
    if ((state == ST_FIN) && out_free) begin
      m_axis_tdata    <= '0;
      m_axis_tuser[0] <= !yr_ok;
      if (yr_ok) begin
        m_axis_tdata[dtas_pkg::OUT_YEAR_LSB +: dtas_pkg::YEAR_W] <= yr[dtas_pkg::YEAR_W-1:0];
        m_axis_tdata[dtas_pkg::OUT_MON_LSB +: dtas_pkg::MON_W]   <= mon;
        m_axis_tdata[dtas_pkg::OUT_DAY_LSB +: dtas_pkg::DAY_W]   <= day[dtas_pkg::DAY_W-1:0];
        m_axis_tdata[dtas_pkg::OUT_HOUR_LSB +: dtas_pkg::HOUR_W] <= hr;
        m_axis_tdata[dtas_pkg::OUT_MIN_LSB +: dtas_pkg::MIN_W]   <= mn;
        m_axis_tdata[dtas_pkg::OUT_SEC_LSB +: dtas_pkg::SEC_W]   <= sc;
      end else begin
        m_axis_tdata[dtas_pkg::OUT_YEAR_LSB +: dtas_pkg::YEAR_W] <= b_yr;
        m_axis_tdata[dtas_pkg::OUT_MON_LSB +: dtas_pkg::MON_W]   <= b_mon;
        m_axis_tdata[dtas_pkg::OUT_DAY_LSB +: dtas_pkg::DAY_W]   <= b_day;
        m_axis_tdata[dtas_pkg::OUT_HOUR_LSB +: dtas_pkg::HOUR_W] <= b_hr;
        m_axis_tdata[dtas_pkg::OUT_MIN_LSB +: dtas_pkg::MIN_W]   <= b_mn;
        m_axis_tdata[dtas_pkg::OUT_SEC_LSB +: dtas_pkg::SEC_W]   <= b_sc;
      end
    end
  end

endmodule

`default_nettype wire
